// ===== design/ymcrc_pkg.sv =====
`default_nettype none

package ymcrc_pkg;

	localparam int SHORT_BLOCK = 128;
	localparam int LONG_BLOCK  = 1024;
	localparam int LEN_W       = 11;

	localparam logic [LEN_W-1:0] BLK_SHORT = LEN_W'(SHORT_BLOCK);
	localparam logic [LEN_W-1:0] BLK_LONG  = LEN_W'(LONG_BLOCK);

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C   = 8'h43;
	localparam logic [7:0] B_NUL = 8'h00;
	localparam logic [7:0] B_FF  = 8'hff;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [1:0] {
		PH_BLOCK0 = 2'd0,
		PH_DATA   = 2'd1,
		PH_EOT1   = 2'd2,
		PH_EOT2   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		FP_NAME  = 3'd0,
		FP_SIZE  = 3'd1,
		FP_SKIP  = 3'd2,
		FP_DONE  = 3'd3,
		FP_EMPTY = 3'd4
	} field_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic             payload_valid;
		logic [7:0]       payload_byte;
		logic [7:0]       reply_byte;
		logic             send_c;
		logic [LEN_W-1:0] commit_len;
		logic             file_done;
		logic             session_end;
		logic             error_flag;
	} out_item_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/ymodem_crc_receiver.sv =====
`default_nettype none

// Channel  Valid      Stall      Payload  Direction
// req      req_valid  req_stall  req      in   (one byte or poll per item)
// rsp      rsp_valid  rsp_stall  rsp      out  (one result per item)
//
// One item per cycle sustained while rsp_stall is low; an accepted item passes the input
// register, then the result register after the CRC/parse update.
// Reset clears all session state; the block then waits for block zero.
// A stalled result holds the result register; req_stall rises only while
// the input register is full and the result register cannot drain.
module ymodem_crc_receiver (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       req_valid,
	output logic                      req_stall,
	input  wire ymcrc_pkg::in_item_t  req,
	output logic                      rsp_valid,
	input  wire                       rsp_stall,
	output ymcrc_pkg::out_item_t      rsp
);
	import ymcrc_pkg::*;

	logic      valid_s1;
	in_item_t  req_s1;
	logic      valid_s2;
	out_item_t rsp_s2;
	logic      out_free;
	logic      adv;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] pos_q, pos_d;
	logic             long_q, long_d;
	logic [7:0]       seq_q, seq_d;
	logic             hdr_ok_q, hdr_ok_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       crc_hi_q, crc_hi_d;
	logic [31:0]      flen_q, flen_d;
	logic [31:0]      bw_q, bw_d;
	field_t           fp_q, fp_d;

	logic [7:0]       b;
	logic             is_poll;
	logic             is_can;
	logic             in_pkt;
	logic [LEN_W-1:0] plen;
	logic [LEN_W-1:0] crc_hi_pos;
	logic             at_start;
	logic             at_payload;
	logic             at_crc_hi;
	logic             at_crc_lo;
	logic             crc_ok;
	logic             blk_good;
	logic             sess_end;
	logic             pkt_err;
	logic [35:0]      flen_mac;
	logic [31:0]      flen_next;
	logic [31:0]      rem;
	logic             rem_gt;
	logic [LEN_W-1:0] commit;
	logic [31:0]      bw_new;
	logic             file_end;
	out_item_t        rsp_d;

	assign out_free  = !valid_s2 || !rsp_stall;
	assign adv       = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	assign b          = req_s1.rx_byte;
	assign is_poll    = req_s1.req_type;
	assign is_can     = !is_poll && (b == B_CAN)
		&& ((phase_q == PH_EOT1) || (phase_q == PH_EOT2) || (pos_q == '0));
	assign in_pkt     = !is_poll && !is_can && ((phase_q == PH_BLOCK0) || (phase_q == PH_DATA));
	assign plen       = ((phase_q == PH_DATA) && long_q) ? BLK_LONG : BLK_SHORT;
	assign crc_hi_pos = plen + LEN_W'(3);
	assign at_start   = (pos_q == '0);
	assign at_payload = (pos_q >= LEN_W'(3)) && (pos_q < crc_hi_pos);
	assign at_crc_hi  = (pos_q == crc_hi_pos);
	assign at_crc_lo  = !at_start && (pos_q != LEN_W'(1)) && (pos_q != LEN_W'(2))
		&& !at_payload && !at_crc_hi;
	assign crc_ok     = hdr_ok_q && ({crc_hi_q, b} == crc_q);
	assign blk_good   = in_pkt && at_crc_lo && crc_ok;
	assign sess_end   = is_can || (blk_good && (phase_q == PH_BLOCK0) && (fp_q == FP_EMPTY));

	assign pkt_err = !is_poll && !is_can && (
		((phase_q == PH_EOT2) && (b != B_EOT))
		|| (in_pkt && at_start && (phase_q == PH_DATA) && (b != B_SOH) && (b != B_STX))
		|| (in_pkt && at_crc_lo && !crc_ok)
		|| (blk_good && (phase_q == PH_BLOCK0) && (fp_q != FP_EMPTY) && (fp_q != FP_DONE)));

	assign flen_mac  = {1'b0, flen_q, 3'b000} + {3'b000, flen_q, 1'b0} + {28'd0, b - 8'h30};
	assign flen_next = (|flen_mac[35:32]) ? 32'hffff_ffff : flen_mac[31:0];

	assign rem      = (flen_q > bw_q) ? (flen_q - bw_q) : 32'd0;
	assign rem_gt   = rem > {{(32-LEN_W){1'b0}}, plen};
	assign commit   = rem_gt ? plen : rem[LEN_W-1:0];
	assign bw_new   = rem_gt ? (bw_q + {{(32-LEN_W){1'b0}}, plen})
		: ((flen_q > bw_q) ? flen_q : bw_q);
	assign file_end = (flen_q != '0) && !rem_gt;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		long_d   = long_q;
		seq_d    = seq_q;
		hdr_ok_d = hdr_ok_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		flen_d   = flen_q;
		bw_d     = bw_q;
		fp_d     = fp_q;
		if (!is_poll && !is_can) begin
			case (phase_q)
				PH_EOT1: begin
					phase_d = PH_EOT2;
					pos_d   = '0;
				end
				PH_EOT2: begin
					if (b == B_EOT) begin
						phase_d = PH_BLOCK0;
						pos_d   = '0;
					end
				end
				default: begin
					if (at_start) begin
						crc_d = '0;
						if (phase_q == PH_BLOCK0) begin
							hdr_ok_d = (b == B_SOH);
							flen_d   = '0;
							fp_d     = FP_NAME;
							pos_d    = LEN_W'(1);
						end else if ((b == B_SOH) || (b == B_STX)) begin
							hdr_ok_d = 1'b1;
							long_d   = (b == B_STX);
							pos_d    = LEN_W'(1);
						end
					end else if (pos_q == LEN_W'(1)) begin
						if (b != ((phase_q == PH_BLOCK0) ? B_NUL : seq_q)) begin
							hdr_ok_d = 1'b0;
						end
						pos_d = pos_q + LEN_W'(1);
					end else if (pos_q == LEN_W'(2)) begin
						if (b != ((phase_q == PH_BLOCK0) ? B_FF : ~seq_q)) begin
							hdr_ok_d = 1'b0;
						end
						pos_d = pos_q + LEN_W'(1);
					end else if (at_payload) begin
						crc_d = crc16_byte(crc_q, b);
						if (phase_q == PH_BLOCK0) begin
							case (fp_q)
								FP_NAME: begin
									if (b == B_NUL) begin
										fp_d = (pos_q == LEN_W'(3)) ? FP_EMPTY : FP_SIZE;
									end
								end
								FP_SIZE: begin
									if (b == B_NUL) begin
										fp_d = FP_DONE;
									end else if (b inside {[8'h30:8'h39]}) begin
										flen_d = flen_next;
									end else begin
										fp_d = FP_SKIP;
									end
								end
								FP_SKIP: begin
									if (b == B_NUL) begin
										fp_d = FP_DONE;
									end
								end
								default: begin
								end
							endcase
						end
						pos_d = pos_q + LEN_W'(1);
					end else if (at_crc_hi) begin
						crc_hi_d = b;
						pos_d    = pos_q + LEN_W'(1);
					end else begin
						pos_d = '0;
						if (crc_ok) begin
							if (phase_q == PH_BLOCK0) begin
								if (fp_q == FP_DONE) begin
									phase_d = PH_DATA;
									seq_d   = 8'd1;
									bw_d    = '0;
								end
							end else begin
								bw_d  = bw_new;
								seq_d = seq_q + 8'd1;
								if (file_end) begin
									phase_d = PH_EOT1;
								end
							end
						end
					end
				end
			endcase
		end
		if (pkt_err) begin
			pos_d = '0;
		end
		if (sess_end) begin
			phase_d  = PH_BLOCK0;
			pos_d    = '0;
			long_d   = 1'b0;
			seq_d    = '0;
			hdr_ok_d = 1'b0;
			crc_d    = '0;
			crc_hi_d = '0;
			flen_d   = '0;
			bw_d     = '0;
			fp_d     = FP_NAME;
		end
	end

	always_comb begin
		rsp_d = '0;
		if (is_poll) begin
			if (phase_q == PH_BLOCK0) begin
				rsp_d.reply_byte = B_C;
			end
		end else if (sess_end) begin
			rsp_d.reply_byte  = B_ACK;
			rsp_d.session_end = 1'b1;
		end else if (phase_q == PH_EOT1) begin
			rsp_d.reply_byte = B_NAK;
		end else if (phase_q == PH_EOT2) begin
			rsp_d.reply_byte = B_ACK;
			rsp_d.send_c     = 1'b1;
		end else if (at_payload && (phase_q == PH_DATA)) begin
			rsp_d.payload_valid = 1'b1;
			rsp_d.payload_byte  = b;
		end else if (blk_good) begin
			rsp_d.reply_byte = B_ACK;
			if (phase_q == PH_BLOCK0) begin
				rsp_d.send_c = 1'b1;
			end else begin
				rsp_d.commit_len = commit;
				rsp_d.file_done  = file_end;
			end
		end
		if (pkt_err) begin
			rsp_d.reply_byte = B_NAK;
			rsp_d.send_c     = 1'b0;
			rsp_d.error_flag = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_s2 <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BLOCK0;
			pos_q    <= '0;
			long_q   <= 1'b0;
			seq_q    <= '0;
			hdr_ok_q <= 1'b0;
			crc_q    <= '0;
			crc_hi_q <= '0;
			flen_q   <= '0;
			bw_q     <= '0;
			fp_q     <= FP_NAME;
		end else if (adv) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			long_q   <= long_d;
			seq_q    <= seq_d;
			hdr_ok_q <= hdr_ok_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			flen_q   <= flen_d;
			bw_q     <= bw_d;
			fp_q     <= fp_d;
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_ymodem_crc_receiver.sv =====
module tb_ymodem_crc_receiver;
	import ymcrc_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int CLK_PERIOD   = 2 * CLK_HALF;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int HOLD_CYCLES  = 200;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 1350;

	typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_SEQ, FLAW_INV, FLAW_START} flaw_t;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      req_valid  = 1'b0;
	logic      req_stall;
	in_item_t  req        = '0;
	logic      rsp_valid;
	logic      rsp_stall  = 1'b0;
	out_item_t rsp;

	bit hold_off   = 1'b0;
	bit rx_idle_en = 1'b1;
	bit tx_idle_en = 1'b1;
	int stall_run  = 0;
	int item_cnt   = 0;
	int err_cnt    = 0;

	out_item_t  pending_replies[$];
	logic [7:0] frame_body[$];

	phase_t      rx_phase;
	logic [10:0] pkt_pos;
	bit          long_blk;
	logic [7:0]  seq_exp;
	bit          hdr_ok;
	logic [15:0] crc_acc;
	logic [7:0]  crc_hi;
	logic [31:0] file_len;
	logic [31:0] written;
	field_t      fprog;

	ymodem_crc_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			if (c[15] ^ b[i]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic void session_clear();
		rx_phase = PH_BLOCK0;
		pkt_pos  = '0;
		long_blk = 1'b0;
		seq_exp  = '0;
		hdr_ok   = 1'b0;
		crc_acc  = '0;
		crc_hi   = '0;
		file_len = '0;
		written  = '0;
		fprog    = FP_NAME;
	endfunction

	function automatic void parse_block0(input logic [7:0] b);
		logic [35:0] grown;
		case (fprog)
			FP_NAME: begin
				if (b == B_NUL) fprog = (pkt_pos == 3) ? FP_EMPTY : FP_SIZE;
			end
			FP_SIZE: begin
				if (b == B_NUL) begin
					fprog = FP_DONE;
				end else if (b >= "0" && b <= "9") begin
					grown = file_len * 36'd10 + (b - "0");
					file_len = (grown > 36'hFFFF_FFFF) ? '1 : grown[31:0];
				end else begin
					fprog = FP_SKIP;
				end
			end
			FP_SKIP: begin
				if (b == B_NUL) fprog = FP_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic out_item_t predict_reply(input in_item_t it);
		out_item_t   r;
		logic [7:0]  b;
		logic [10:0] plen;
		logic [31:0] room;
		logic [10:0] keep;
		bit          bad;
		r    = '0;
		b    = it.rx_byte;
		bad  = 1'b0;
		plen = (rx_phase == PH_DATA && long_blk) ? BLK_LONG : BLK_SHORT;
		if (it.req_type) begin
			if (rx_phase == PH_BLOCK0) r.reply_byte = B_C;
		end else if (b == B_CAN && (rx_phase == PH_EOT1 || rx_phase == PH_EOT2 || pkt_pos == 0)) begin
			session_clear();
			r.reply_byte  = B_ACK;
			r.session_end = 1'b1;
		end else if (rx_phase == PH_EOT1) begin
			rx_phase     = PH_EOT2;
			pkt_pos      = '0;
			r.reply_byte = B_NAK;
		end else if (rx_phase == PH_EOT2) begin
			if (b == B_EOT) begin
				rx_phase     = PH_BLOCK0;
				pkt_pos      = '0;
				r.reply_byte = B_ACK;
				r.send_c     = 1'b1;
			end else begin
				bad = 1'b1;
			end
		end else if (pkt_pos == 0) begin
			crc_acc = '0;
			if (rx_phase == PH_BLOCK0) begin
				hdr_ok   = (b == B_SOH);
				file_len = '0;
				fprog    = FP_NAME;
				pkt_pos  = 11'd1;
			end else if (b == B_SOH || b == B_STX) begin
				hdr_ok   = 1'b1;
				long_blk = (b == B_STX);
				pkt_pos  = 11'd1;
			end else begin
				bad = 1'b1;
			end
		end else if (pkt_pos == 1) begin
			if (b != (rx_phase == PH_BLOCK0 ? B_NUL : seq_exp)) hdr_ok = 1'b0;
			pkt_pos++;
		end else if (pkt_pos == 2) begin
			if (b != (rx_phase == PH_BLOCK0 ? B_FF : ~seq_exp)) hdr_ok = 1'b0;
			pkt_pos++;
		end else if (pkt_pos < plen + 3) begin
			crc_acc = crc_next(crc_acc, b);
			if (rx_phase == PH_BLOCK0) begin
				parse_block0(b);
			end else begin
				r.payload_valid = 1'b1;
				r.payload_byte  = b;
			end
			pkt_pos++;
		end else if (pkt_pos == plen + 3) begin
			crc_hi = b;
			pkt_pos++;
		end else begin
			pkt_pos = '0;
			if (!hdr_ok || {crc_hi, b} != crc_acc) begin
				bad = 1'b1;
			end else if (rx_phase == PH_BLOCK0) begin
				if (fprog == FP_EMPTY) begin
					session_clear();
					r.reply_byte  = B_ACK;
					r.session_end = 1'b1;
				end else if (fprog != FP_DONE) begin
					bad = 1'b1;
				end else begin
					rx_phase     = PH_DATA;
					seq_exp      = 8'd1;
					written      = '0;
					r.reply_byte = B_ACK;
					r.send_c     = 1'b1;
				end
			end else begin
				room         = (file_len > written) ? file_len - written : '0;
				keep         = (room > plen) ? plen : room[10:0];
				written      = written + keep;
				r.commit_len = keep;
				seq_exp++;
				r.reply_byte = B_ACK;
				if (file_len != 0 && written >= file_len) begin
					rx_phase    = PH_EOT1;
					r.file_done = 1'b1;
				end
			end
		end
		if (bad) begin
			pkt_pos      = '0;
			r.reply_byte = B_NAK;
			r.send_c     = 1'b0;
			r.error_flag = 1'b1;
		end
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] stray_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == B_SOH || b == B_STX || b == B_EOT || b == B_CAN);
		return b;
	endfunction

	always @(posedge clk) begin
		if (stall_run == 0 && rx_idle_en && $urandom_range(0, 99) < 25) begin
			stall_run = idle_len();
		end
		rsp_stall <= hold_off || stall_run > 0;
		if (stall_run > 0) begin
			stall_run--;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS) $display("unexpected result %h", rsp);
			end else begin
				want = pending_replies.pop_front();
				if (rsp.payload_valid !== want.payload_valid ||
				    rsp.payload_byte !== want.payload_byte ||
				    rsp.reply_byte !== want.reply_byte || rsp.send_c !== want.send_c ||
				    rsp.commit_len !== want.commit_len || rsp.file_done !== want.file_done ||
				    rsp.session_end !== want.session_end ||
				    rsp.error_flag !== want.error_flag) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("mismatch at %0t: pv/pb/rep/c/len/fd/se/err",  $realtime);
						$display("  want %0b %h %h %0b %0d %0b %0b %0b",
							want.payload_valid, want.payload_byte, want.reply_byte,
							want.send_c, want.commit_len, want.file_done,
							want.session_end, want.error_flag);
						$display("  got  %0b %h %h %0b %0d %0b %0b %0b",
							rsp.payload_valid, rsp.payload_byte, rsp.reply_byte,
							rsp.send_c, rsp.commit_len, rsp.file_done,
							rsp.session_end, rsp.error_flag);
					end
				end
			end
		end
	end

	task automatic send_item(input in_item_t it);
		int gap;
		gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_replies.push_back(predict_reply(it));
		item_cnt++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_item_t it;
		it.req_type = 1'b0;
		it.rx_byte  = b;
		send_item(it);
	endtask

	task automatic send_poll();
		in_item_t it;
		it.req_type = 1'b1;
		it.rx_byte  = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	task automatic send_packet(input logic [7:0] start, input logic [7:0] seq,
			input logic [7:0] seq_inv, input logic [15:0] crc_flip);
		logic [15:0] crc;
		crc = '0;
		foreach (frame_body[i]) crc = crc_next(crc, frame_body[i]);
		crc = crc ^ crc_flip;
		send_byte(start);
		send_byte(seq);
		send_byte(seq_inv);
		foreach (frame_body[i]) send_byte(frame_body[i]);
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
	endtask

	task automatic fill_block0(input int name_len, input string size_txt);
		frame_body.delete();
		repeat (name_len) frame_body.push_back(8'($urandom_range(1, 255)));
		frame_body.push_back(B_NUL);
		for (int i = 0; i < size_txt.len(); i++) frame_body.push_back(size_txt[i]);
		frame_body.push_back(B_NUL);
		while (frame_body.size() < SHORT_BLOCK) frame_body.push_back(B_NUL);
	endtask

	task automatic fill_random(input int n);
		frame_body.delete();
		repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
		frame_body[$urandom_range(0, n - 1)] = B_CAN;
	endtask

	task automatic send_block0(input int name_len, input string size_txt);
		fill_block0(name_len, size_txt);
		send_packet(B_SOH, B_NUL, B_FF, '0);
	endtask

	task automatic send_data_block(input bit long_one, input flaw_t flaw);
		logic [7:0]  seq;
		logic [7:0]  seq_inv;
		logic [15:0] flip;
		seq     = seq_exp;
		seq_inv = ~seq_exp;
		flip    = '0;
		case (flaw)
			FLAW_CRC: flip = 16'h1 << $urandom_range(0, 15);
			FLAW_SEQ: seq = seq_exp + 8'd1;
			FLAW_INV: seq_inv = seq_exp;
			default: ;
		endcase
		if (flaw == FLAW_START) begin
			send_byte(stray_byte());
		end else begin
			fill_random(long_one ? LONG_BLOCK : SHORT_BLOCK);
			send_packet(long_one ? B_STX : B_SOH, seq, seq_inv, flip);
		end
	endtask

	// finish any open packet, then cancel back to the start of a session
	task automatic resync();
		while (pkt_pos != 0) send_byte(8'($urandom_range(0, 255)));
		if (rx_phase != PH_BLOCK0) send_byte(B_CAN);
	endtask

	task automatic test_poll_and_cancel();
		send_poll();
		send_byte(B_CAN);
		send_poll();
	endtask

	task automatic test_block0_rejects();
		fill_block0(3, "10");
		send_packet(B_STX, B_NUL, B_FF, '0);
		send_packet(B_SOH, 8'h01, B_FF, '0);
		send_packet(B_SOH, B_NUL, 8'hFE, '0);
		send_packet(B_SOH, B_NUL, B_FF, 16'h8001);
		fill_random(SHORT_BLOCK);
		foreach (frame_body[i]) if (frame_body[i] == B_NUL) frame_body[i] = B_CAN;
		send_packet(B_SOH, B_NUL, B_FF, '0);
		fill_block0(2, "");
		for (int i = 3; i < SHORT_BLOCK; i++) frame_body[i] = "9";
		send_packet(B_SOH, B_NUL, B_FF, '0);
	endtask

	task automatic test_block0_fields();
		send_block0(0, "500");
		send_block0(5, "99999999999");
		send_byte(B_CAN);
		send_block0(4, "12x34");
		send_data_block(1'b0, FLAW_NONE);
		send_byte(B_EOT);
		send_byte(B_CAN);
	endtask

	task automatic test_short_file();
		send_poll();
		send_block0(8, "300 13 644");
		send_byte(B_EOT);
		send_poll();
		send_data_block(1'b0, FLAW_NONE);
		send_data_block(1'b0, FLAW_SEQ);
		send_data_block(1'b0, FLAW_INV);
		send_data_block(1'b0, FLAW_CRC);
		send_data_block(1'b0, FLAW_NONE);
		send_data_block(1'b0, FLAW_NONE);
		send_poll();
		send_byte(B_NUL);
		send_byte(8'h55);
		send_poll();
		send_byte(B_EOT);
		send_poll();
	endtask

	task automatic test_size_zero();
		send_block0(2, "abc");
		send_data_block(1'b0, FLAW_NONE);
		send_data_block(1'b0, FLAW_NONE);
		send_byte(B_CAN);
	endtask

	task automatic test_long_block();
		send_block0(6, "1100");
		send_data_block(1'b0, FLAW_NONE);
		send_data_block(1'b1, FLAW_NONE);
		send_byte(B_EOT);
		send_byte(B_EOT);
	endtask

	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
			begin
				send_block0(3, "200");
				send_data_block(1'b0, FLAW_NONE);
			end
		join
		tx_idle_en = 1'b1;
		resync();
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 16);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0) send_poll();
			else send_byte(8'($urandom_range(0, 255)));
		end
		resync();
	endtask

	task automatic run_session();
		int    pick;
		int    blocks;
		string size_txt;
		flaw_t flaw;
		pick = $urandom_range(0, 99);
		if (pick < 8) size_txt = "0";
		else if (pick < 12) size_txt = "";
		else if (pick < 18) size_txt = $sformatf("%0d", SHORT_BLOCK * $urandom_range(1, 3));
		else if (pick < 22) size_txt = "4294967295999";
		else size_txt = $sformatf("%0d", $urandom_range(1, 700));
		if ($urandom_range(0, 1)) size_txt = {size_txt, " 3 100644"};
		if ($urandom_range(0, 99) < 30) send_poll();
		pick = $urandom_range(0, 99);
		fill_block0(pick < 4 ? 0 : $urandom_range(1, 12), size_txt);
		if (pick >= 4 && pick < 8) send_packet(B_SOH, B_NUL, B_FF, 16'h1 << $urandom_range(0, 15));
		else if (pick >= 8 && pick < 10) send_packet(stray_byte(), B_NUL, B_FF, '0);
		else send_packet(B_SOH, B_NUL, B_FF, '0);
		blocks = 0;
		while (rx_phase == PH_DATA && blocks < 8) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_byte(B_CAN);
			end else begin
				if (pick < 10) send_poll();
				flaw = pick < 15 ? FLAW_CRC : pick < 19 ? FLAW_SEQ : pick < 22 ? FLAW_INV :
					pick < 26 ? FLAW_START : FLAW_NONE;
				send_data_block($urandom_range(0, 99) < 6, flaw);
			end
			blocks++;
		end
		if (rx_phase == PH_EOT1) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) send_byte(B_CAN);
			else send_byte(pick < 18 ? stray_byte() : B_EOT);
			if (rx_phase == PH_EOT2) begin
				if ($urandom_range(0, 99) < 15) send_byte(stray_byte());
				if ($urandom_range(0, 99) < 15) send_poll();
				send_byte($urandom_range(0, 99) < 8 ? B_CAN : B_EOT);
			end
		end
		resync();
	endtask

	task automatic test_random_sessions(input int budget);
		int stop_at;
		stop_at = item_cnt + budget;
		while (item_cnt < stop_at) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 12) send_noise();
			else run_session();
		end
		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
	endtask

	initial begin
		session_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_poll_and_cancel();
		test_block0_rejects();
		test_block0_fields();
		test_short_file();
		test_size_zero();
		test_long_block();
		test_backpressure();
		test_random_sessions(RANDOM_ITEMS);
		req_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && pending_replies.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results outstanding", pending_replies.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
